// ----- sv/pjss_pkg.sv -----
// Shared types, codes and field widths for the pressure jump source scatter block.
`timescale 1ns / 1ps
`default_nettype none

package pjss_pkg;

    localparam int CNT_W   = 7;
    localparam int COORD_W = 6;
    localparam int INV_W   = 48;
    localparam int JUMP_W  = 32;
    localparam int VAL_W   = 64;
    localparam int MAG_W   = 63;
    localparam int IDX_W   = 18;
    localparam int TMP_W   = 12;
    localparam int PROD_W  = 56;
    localparam int KEY_W   = 20;
    localparam int REG_W   = 3;
    localparam int SDATA_W = 56;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_FACE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [REG_W-1:0] REG_CELLS_X = 3'd0;
    localparam logic [REG_W-1:0] REG_CELLS_Y = 3'd1;
    localparam logic [REG_W-1:0] REG_CELLS_Z = 3'd2;
    localparam logic [REG_W-1:0] REG_INV_DX  = 3'd3;
    localparam logic [REG_W-1:0] REG_INV_DY  = 3'd4;
    localparam logic [REG_W-1:0] REG_INV_DZ  = 3'd5;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_IDX0,
        S_IDX1,
        S_EVAL,
        S_UPD_M,
        S_RD_P,
        S_UPD_P,
        S_GET,
        S_DONE
    } pjss_state_t;

    typedef struct packed {
        logic idx0;
        logic idx1;
        logic fin;
    } pjss_calc_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] plus_idx;
        logic [IDX_W-1:0] minus_idx;
        logic [MAG_W-1:0] mag;
        logic             cap_sat;
    } pjss_calc_res_t;

endpackage

`default_nettype wire

// ----- sv/pressure_jump_source_scatter_top.sv -----
// Top level: configuration, item sequencer and read-modify-write of the source store.
//
//  channel  | signals                            | direction | word
//  ---------+------------------------------------+-----------+--------------------------------
//  s        | s_tvalid s_tready s_tdata s_tuser  | in        | kind, face or cell, jump
//  m        | m_tvalid m_tready m_tdata m_tuser  | out       | source value, status
//  cfg      | cfg_valid cfg_ready cfg_index/data | in        | register index and value
//
// One item at a time. A face is bound by two read-modify-write passes on the store's
// single write port, a clear by its zeroing sweep. After reset a sweep zeroes the
// store with s_tready low; cfg is always ready.
// The output register holds one result, so the next word is taken while it waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none

module pressure_jump_source_scatter_top #(
    parameter int MAX_CELLS = 4096,
    parameter int MAX_DIM   = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] axis, [7:2] col_i, [13:8] row_j, [19:14] layer_k, [51:20] jump_value
    input  wire logic [55:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [63:0] source_value
    output logic      [63:0] m_tdata,
    // [1:0] status
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    import pjss_pkg::*;

    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LIM_W  = IDX_W + 1;
    localparam logic [LIM_W-1:0]  CELLS_LIM = LIM_W'(MAX_CELLS);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MAX_CELLS - 1);
    localparam logic [CNT_W-1:0]  DIM_LIM   = CNT_W'(MAX_DIM);

    pjss_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cells_x_reg, cells_x_next, cells_y_reg, cells_y_next;
    logic [CNT_W-1:0]  cells_z_reg, cells_z_next;
    logic [INV_W-1:0]  inv_dx_reg, inv_dx_next, inv_dy_reg, inv_dy_next;
    logic [INV_W-1:0]  inv_dz_reg, inv_dz_next;

    logic [1:0]         kind_reg, kind_next, axis_reg, axis_next;
    logic [COORD_W-1:0] col_reg, col_next, row_reg, row_next, layer_reg, layer_next;
    logic [JUMP_W-1:0]  jump_reg, jump_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              sat_reg, sat_next;
    logic [KEY_W-1:0]  last_key_reg, last_key_next;
    logic              last_valid_reg, last_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic [1:0]       s_kind;
    logic [CNT_W-1:0] cx, cy, cz;
    logic [INV_W-1:0] inv_sel;
    logic             in_range, axis_ok, plus_ok, minus_ok, dup, face_ok, read_ok;
    logic             clr_last, out_free;
    logic [KEY_W-1:0] key;

    pjss_calc_ctrl_t calc_ctrl;
    pjss_calc_res_t  calc_res;

    logic              mem_we, sub_op;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [VAL_W-1:0]  mem_wdata, mem_rdata;
    logic [VAL_W:0]    acc_ext;
    logic              acc_ovf;
    logic [VAL_W-1:0]  acc_sat;

    assign s_kind   = s_tuser;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    assign cx = (cells_x_reg > DIM_LIM) ? DIM_LIM : cells_x_reg;
    assign cy = (cells_y_reg > DIM_LIM) ? DIM_LIM : cells_y_reg;
    assign cz = (cells_z_reg > DIM_LIM) ? DIM_LIM : cells_z_reg;

    always_comb
    begin
        case (axis_reg)
            AX_X:    inv_sel = inv_dx_reg;
            AX_Y:    inv_sel = inv_dy_reg;
            AX_Z:    inv_sel = inv_dz_reg;
            default: inv_sel = '0;
        endcase
    end

    pjss_calc u_calc (
        .clk        (clk),
        .ctrl       (calc_ctrl),
        .axis       (axis_reg),
        .col_i      (col_reg),
        .row_j      (row_reg),
        .layer_k    (layer_reg),
        .jump_value (jump_reg),
        .cx         (cx),
        .cy         (cy),
        .cz         (cz),
        .inv        (inv_sel),
        .res        (calc_res)
    );

    pjss_store #(
        .DEPTH  (MAX_CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Checks on the latched item.
    always_comb
    begin
        in_range = ({1'b0, col_reg} < cx) && ({1'b0, row_reg} < cy)
                   && ({1'b0, layer_reg} < cz);
        axis_ok  = (axis_reg == AX_X) || (axis_reg == AX_Y) || (axis_reg == AX_Z);
        plus_ok  = {1'b0, calc_res.plus_idx} < CELLS_LIM;
        minus_ok = {1'b0, calc_res.minus_idx} < CELLS_LIM;
        key      = {axis_reg, layer_reg, row_reg, col_reg};
        dup      = last_valid_reg && (last_key_reg == key);
        face_ok  = axis_ok && in_range && plus_ok && minus_ok;
        read_ok  = in_range && plus_ok;
        clr_last = clr_cnt_reg == CLR_LAST;
        out_free = !out_valid_reg || m_tready;
    end

    // Saturating add or subtract of the magnitude on the word read back.
    always_comb
    begin
        if (sub_op)
        begin
            acc_ext = {mem_rdata[VAL_W-1], mem_rdata} - {2'b00, calc_res.mag};
        end
        else
        begin
            acc_ext = {mem_rdata[VAL_W-1], mem_rdata} + {2'b00, calc_res.mag};
        end
        acc_ovf = acc_ext[VAL_W] ^ acc_ext[VAL_W-1];
        if (acc_ovf)
        begin
            acc_sat = acc_ext[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_ext[VAL_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_kind)
                        KIND_CLEAR: state_next = S_CLEAR;
                        KIND_FACE:  state_next = S_IDX0;
                        KIND_READ:  state_next = S_IDX0;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_IDX0:  state_next = S_IDX1;
            S_IDX1:  state_next = S_EVAL;
            S_EVAL:
            begin
                if (kind_reg == KIND_FACE && face_ok && !dup)
                begin
                    state_next = S_UPD_M;
                end
                else if (kind_reg == KIND_READ && read_ok)
                begin
                    state_next = S_GET;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UPD_M: state_next = S_RD_P;
            S_RD_P:  state_next = S_UPD_P;
            S_UPD_P: state_next = S_DONE;
            S_GET:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs: handshake, calc steps and store port control.
    always_comb
    begin
        s_tready       = 1'b0;
        calc_ctrl.idx0 = 1'b0;
        calc_ctrl.idx1 = 1'b0;
        calc_ctrl.fin  = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = calc_res.plus_idx[ADDR_W-1:0];
        mem_wdata      = acc_sat;
        mem_raddr      = calc_res.plus_idx[ADDR_W-1:0];
        sub_op         = 1'b0;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            S_IDLE:  s_tready = 1'b1;
            S_IDX0:  calc_ctrl.idx0 = 1'b1;
            S_IDX1:  calc_ctrl.idx1 = 1'b1;
            S_EVAL:
            begin
                calc_ctrl.fin = 1'b1;
                if (kind_reg == KIND_FACE)
                begin
                    mem_raddr = calc_res.minus_idx[ADDR_W-1:0];
                end
            end
            S_UPD_M:
            begin
                // minus cell takes +c
                mem_we    = 1'b1;
                mem_waddr = calc_res.minus_idx[ADDR_W-1:0];
                sub_op    = jump_reg[JUMP_W-1];
            end
            S_UPD_P:
            begin
                // plus cell takes -c
                mem_we = 1'b1;
                sub_op = !jump_reg[JUMP_W-1];
            end
            default: ;
        endcase
    end

    // Datapath and configuration next values.
    always_comb
    begin
        cells_x_next    = cells_x_reg;
        cells_y_next    = cells_y_reg;
        cells_z_next    = cells_z_reg;
        inv_dx_next     = inv_dx_reg;
        inv_dy_next     = inv_dy_reg;
        inv_dz_next     = inv_dz_reg;
        kind_next       = kind_reg;
        axis_next       = axis_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        layer_next      = layer_reg;
        jump_next       = jump_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        sat_next        = sat_reg;
        last_key_next   = last_key_reg;
        last_valid_next = last_valid_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CELLS_X: cells_x_next = cfg_data[CNT_W-1:0];
                REG_CELLS_Y: cells_y_next = cfg_data[CNT_W-1:0];
                REG_CELLS_Z: cells_z_next = cfg_data[CNT_W-1:0];
                REG_INV_DX:  inv_dx_next  = cfg_data;
                REG_INV_DY:  inv_dy_next  = cfg_data;
                REG_INV_DZ:  inv_dz_next  = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next       = s_kind;
                    axis_next       = s_tdata[1:0];
                    col_next        = s_tdata[7:2];
                    row_next        = s_tdata[13:8];
                    layer_next      = s_tdata[19:14];
                    jump_next       = s_tdata[51:20];
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    sat_next        = 1'b0;
                    if (s_kind == KIND_CLEAR)
                    begin
                        last_valid_next = 1'b0;
                    end
                end
            end
            S_EVAL:
            begin
                if (kind_reg == KIND_FACE)
                begin
                    if (!face_ok)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else if (dup)
                    begin
                        res_status_next = ST_DUP;
                    end
                end
                else if (kind_reg == KIND_READ && !read_ok)
                begin
                    res_status_next = ST_RANGE;
                end
            end
            S_UPD_M:
            begin
                sat_next = sat_reg || calc_res.cap_sat || acc_ovf;
            end
            S_UPD_P:
            begin
                last_key_next   = key;
                last_valid_next = 1'b1;
                res_status_next = (sat_reg || acc_ovf) ? ST_SAT : ST_OK;
            end
            S_GET:
            begin
                res_value_next = mem_rdata;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cells_x_reg    <= 7'd16;
            cells_y_reg    <= 7'd16;
            cells_z_reg    <= 7'd16;
            inv_dx_reg     <= 48'd65536;
            inv_dy_reg     <= 48'd65536;
            inv_dz_reg     <= 48'd65536;
            clr_cnt_reg    <= '0;
            last_key_reg   <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cells_x_reg    <= cells_x_next;
            cells_y_reg    <= cells_y_next;
            cells_z_reg    <= cells_z_next;
            inv_dx_reg     <= inv_dx_next;
            inv_dy_reg     <= inv_dy_next;
            inv_dz_reg     <= inv_dz_next;
            clr_cnt_reg    <= clr_cnt_next;
            last_key_reg   <= last_key_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        axis_reg       <= axis_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        layer_reg      <= layer_next;
        jump_reg       <= jump_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        sat_reg        <= sat_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ----- sv/pjss_store.sv -----
// Source store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pjss_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [63:0]       wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [63:0]       rdata
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/pjss_calc.sv -----
// Cell index and scaled jump magnitude, computed over three sequenced steps.
`timescale 1ns / 1ps
`default_nettype none

module pjss_calc (
    input  wire logic                      clk,
    input  wire pjss_pkg::pjss_calc_ctrl_t ctrl,
    input  wire logic [1:0]                axis,
    input  wire logic [5:0]                col_i,
    input  wire logic [5:0]                row_j,
    input  wire logic [5:0]                layer_k,
    input  wire logic [31:0]               jump_value,
    input  wire logic [6:0]                cx,
    input  wire logic [6:0]                cy,
    input  wire logic [6:0]                cz,
    input  wire logic [47:0]               inv,
    output pjss_pkg::pjss_calc_res_t       res
);

    import pjss_pkg::*;

    logic [COORD_W-1:0] mi, mj, mk;
    logic [JUMP_W-1:0]  amag;
    logic [23:0]        mul_b;
    logic [PROD_W-1:0]  prod;
    logic [12:0]        tp_prod, tm_prod;
    logic [18:0]        pp_prod, pm_prod;
    logic [63:0]        sum;

    logic [TMP_W-1:0]   tp_reg, tp_next, tm_reg, tm_next;
    logic [IDX_W-1:0]   plus_reg, plus_next, minus_reg, minus_next;
    logic [PROD_W-1:0]  plo_reg, plo_next, phi_reg, phi_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               cap_reg, cap_next;

    // Minus cell: one step back along the face axis, wrapping to count - 1.
    always_comb
    begin
        mi = col_i;
        mj = row_j;
        mk = layer_k;
        case (axis)
            AX_X: mi = (col_i == '0) ? COORD_W'(cx - 7'd1) : col_i - 6'd1;
            AX_Y: mj = (row_j == '0) ? COORD_W'(cy - 7'd1) : row_j - 6'd1;
            AX_Z: mk = (layer_k == '0) ? COORD_W'(cz - 7'd1) : layer_k - 6'd1;
            default: ;
        endcase
    end

    always_comb
    begin
        amag    = jump_value[JUMP_W-1] ? (~jump_value + 32'd1) : jump_value;
        // Split the spacing factor into two 24-bit halves on one multiplier.
        mul_b   = ctrl.idx1 ? inv[47:24] : inv[23:0];
        prod    = amag * mul_b;
        tp_prod = cy * layer_k;
        tm_prod = cy * mk;
        pp_prod = cx * tp_reg;
        pm_prod = cx * tm_reg;
        sum     = {phi_reg, 8'b0} + 64'(plo_reg[PROD_W-1:16]);
    end

    always_comb
    begin
        tp_next    = tp_reg;
        tm_next    = tm_reg;
        plus_next  = plus_reg;
        minus_next = minus_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        mag_next   = mag_reg;
        cap_next   = cap_reg;
        if (ctrl.idx0)
        begin
            tp_next  = TMP_W'(tp_prod + 13'(row_j));
            tm_next  = TMP_W'(tm_prod + 13'(mj));
            plo_next = prod;
        end
        if (ctrl.idx1)
        begin
            plus_next  = IDX_W'(pp_prod + 19'(col_i));
            minus_next = IDX_W'(pm_prod + 19'(mi));
            phi_next   = prod;
        end
        if (ctrl.fin)
        begin
            cap_next = sum[63];
            mag_next = sum[63] ? {MAG_W{1'b1}} : sum[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg    <= tp_next;
        tm_reg    <= tm_next;
        plus_reg  <= plus_next;
        minus_reg <= minus_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        mag_reg   <= mag_next;
        cap_reg   <= cap_next;
    end

    assign res.plus_idx  = plus_reg;
    assign res.minus_idx = minus_reg;
    assign res.mag       = mag_reg;
    assign res.cap_sat   = cap_reg;

endmodule

`default_nettype wire
